>>> src/assb_pkg.sv
// Package for the semaphore set bank: status codes, modes, field types.
// No dependencies; used by every module under src.
package assb_pkg;
    localparam int SemSlotsDef   = 64;
    localparam int ReqBitsDef    = 22;
    localparam int ValueMax      = 32767;

    localparam logic [2:0] MODE_OP     = 3'd0;
    localparam logic [2:0] MODE_SET    = 3'd1;
    localparam logic [2:0] MODE_GETVAL = 3'd2;
    localparam logic [2:0] MODE_GETREQ = 3'd3;
    localparam logic [2:0] MODE_GETWT  = 3'd4;
    localparam logic [2:0] MODE_WAITED = 3'd5;
    localparam logic [2:0] MODE_REMOVE = 3'd6;
    localparam logic [2:0] MODE_RSVD   = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PENDING  = 3'd1;
    localparam logic [2:0] ST_RETRY    = 3'd2;
    localparam logic [2:0] ST_BLOCKED  = 3'd3;
    localparam logic [2:0] ST_BADINDEX = 3'd4;
    localparam logic [2:0] ST_UNSUP    = 3'd5;
    localparam logic [2:0] ST_REMOVED  = 3'd6;
    localparam logic [2:0] ST_RANGE    = 3'd7;
endpackage

>>> src/assb_store.sv
// Per-slot semaphore storage: value, shadow, requester and waiter counts.
// Depends on assb_pkg. Memories with registered reads, one write port each.
module assb_store #(
    parameter int SEM_SLOTS      = assb_pkg::SemSlotsDef,
    parameter int REQUESTER_BITS = assb_pkg::ReqBitsDef,
    parameter int IW             = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1
) (
    input  logic                      i_clk,
    input  logic [IW-1:0]             i_raddr,
    output logic [14:0]               o_val,
    output logic [14:0]               o_shadow,
    output logic [REQUESTER_BITS-1:0] o_req,
    output logic [15:0]               o_wneg,
    output logic [15:0]               o_wzero,
    input  logic [IW-1:0]             i_waddr,
    input  logic                      i_val_we,
    input  logic [14:0]               i_val,
    input  logic                      i_sh_we,
    input  logic [14:0]               i_sh,
    input  logic                      i_req_we,
    input  logic [REQUESTER_BITS-1:0] i_req,
    input  logic                      i_wneg_we,
    input  logic [15:0]               i_wneg,
    input  logic                      i_wz_we,
    input  logic [15:0]               i_wz
);
    logic [14:0]               r_val  [SEM_SLOTS];
    logic [14:0]               r_sh   [SEM_SLOTS];
    logic [REQUESTER_BITS-1:0] r_req  [SEM_SLOTS];
    logic [15:0]               r_wneg [SEM_SLOTS];
    logic [15:0]               r_wz   [SEM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_val_we)  r_val[i_waddr]  <= i_val;
        if (i_sh_we)   r_sh[i_waddr]   <= i_sh;
        if (i_req_we)  r_req[i_waddr]  <= i_req;
        if (i_wneg_we) r_wneg[i_waddr] <= i_wneg;
        if (i_wz_we)   r_wz[i_waddr]   <= i_wz;
        o_val    <= r_val[i_raddr];
        o_shadow <= r_sh[i_raddr];
        o_req    <= r_req[i_raddr];
        o_wneg   <= r_wneg[i_raddr];
        o_wzero  <= r_wz[i_raddr];
    end
endmodule

>>> src/atomic_semaphore_set_bank.sv
// Semaphore set bank: a beat is read in S_RD and executed in S_EXE; the result beat is
// registered, offered in S_OUT and held until taken.
// A blocked close that counts a waiter rereads the stop slot; a clean close walks every
// slot to commit (slots capped at 64).
// Reset: a clearing pass over every slot zeroes values, requesters and waiter counts,
// no beat is taken meanwhile; control state clears and sem_count resets to 64.
module atomic_semaphore_set_bank #(
    parameter int SEM_SLOTS      = assb_pkg::SemSlotsDef,
    parameter int REQUESTER_BITS = assb_pkg::ReqBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write: sem_count
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    // tdata: mode[2:0], sem_index[8:3], sem_delta[24:9], no_wait[25], undo_flag[26],
    // requester_id[26+R:27], new_value[+16], wait_kind[+1], zero pad
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [((44+REQUESTER_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // tdata: status[2:0], read_value[17:3], read_requester[17+R:18],
    // negative_waiters[+16], zero_waiters[+16], blocked_index[+6], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [((56+REQUESTER_BITS+7)/8)*8-1:0] m_axis_tdata
);
    import assb_pkg::*;
    // the index field is 6 bits wide, so no more than 64 slots are reachable
    localparam int SLOTS_USED = (SEM_SLOTS < 64) ? SEM_SLOTS : 64;
    localparam int IW  = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;
    localparam int CW  = $clog2(SLOTS_USED + 1);
    localparam int R   = REQUESTER_BITS;
    localparam int OW  = ((56+R+7)/8)*8;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EXE  = 3'd3;
    localparam logic [2:0] S_CMT  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  r_state;
    logic [CW-1:0] r_cnt;
    logic [6:0]  r_sem_count;
    logic [63:0] r_touched;
    logic [2:0]  r_outcome;
    logic [7:0]  r_bpoint;
    logic        r_removed;
    // held item
    logic [2:0]  r_mode;
    logic [5:0]  r_idx;
    logic [15:0] r_delta;
    logic        r_nowait, r_undo, r_last, r_wkind;
    logic [R-1:0] r_reqid;
    logic [15:0] r_newval;
    logic [OW-1:0] r_out;

    // store ports
    logic [IW-1:0] w_raddr, w_waddr;
    logic [14:0]   w_val, w_sh;
    logic [R-1:0]  w_req;
    logic [15:0]   w_wneg, w_wz;
    logic          w_val_we, w_sh_we, w_req_we, w_wneg_we, w_wz_we;
    logic [14:0]   w_val_d, w_sh_d;
    logic [R-1:0]  w_req_d;
    logic [15:0]   w_wneg_d, w_wz_d;

    // shared unit: one 17-bit signed add
    logic signed [16:0] w_cur, w_sum;
    logic [6:0] w_limit;
    logic       w_inrange, w_idxvalid;
    logic [IW-1:0] w_slot;
    logic       w_swap;

    assign w_slot     = r_idx[IW-1:0];
    assign w_limit    = (r_sem_count < 7'(SLOTS_USED)) ? r_sem_count : 7'(SLOTS_USED);
    assign w_inrange  = {1'b0, r_idx} < w_limit;
    assign w_idxvalid = r_touched[r_idx];
    assign w_cur      = {2'b00, (w_idxvalid ? w_sh : w_val)};
    assign w_sum      = w_cur + {r_delta[15], r_delta};

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;

    // closing element of an already blocked set: read the stop slot instead
    assign w_swap = (r_state == S_RD) && r_mode == MODE_OP && r_last &&
                    r_outcome == ST_BLOCKED;

    // commit reads slot r_cnt while writing slot r_cnt-1
    assign w_raddr = (r_state == S_IDLE) ? s_axis_tdata[3+IW-1:3] :
                     (r_state == S_CMT)  ? r_cnt[IW-1:0] :
                     w_swap              ? r_bpoint[IW-1:0] : w_slot;

    assb_store #(.SEM_SLOTS(SLOTS_USED), .REQUESTER_BITS(R), .IW(IW)) u_store (
        .i_clk(i_clk), .i_raddr(w_raddr),
        .o_val(w_val), .o_shadow(w_sh), .o_req(w_req), .o_wneg(w_wneg), .o_wzero(w_wz),
        .i_waddr(w_waddr), .i_val_we(w_val_we), .i_val(w_val_d),
        .i_sh_we(w_sh_we), .i_sh(w_sh_d), .i_req_we(w_req_we), .i_req(w_req_d),
        .i_wneg_we(w_wneg_we), .i_wneg(w_wneg_d), .i_wz_we(w_wz_we), .i_wz(w_wz_d)
    );

    // store write decode
    always_comb begin
        w_waddr = w_slot; w_val_we = 1'b0; w_sh_we = 1'b0; w_req_we = 1'b0;
        w_wneg_we = 1'b0; w_wz_we = 1'b0;
        w_val_d = r_newval[14:0]; w_sh_d = w_sum[14:0]; w_req_d = r_reqid;
        w_wneg_d = 16'd0; w_wz_d = 16'd0;
        if (r_state == S_CLR) begin
            w_waddr = r_cnt[IW-1:0];
            w_val_we = 1'b1; w_req_we = 1'b1; w_wneg_we = 1'b1; w_wz_we = 1'b1;
            w_val_d = 15'd0; w_req_d = '0;
        end else if (r_state == S_CMT) begin
            // copy shadow to value for each touched slot, one per cycle
            w_val_d = w_sh;
            w_val_we = (r_cnt != CW'(0)) && r_touched[6'(r_cnt - CW'(1))];
            w_req_we = w_val_we;
            w_waddr = IW'(r_cnt - CW'(1));
        end else if (r_state == S_EXE) begin
            case (r_mode)
                MODE_OP: begin
                    if (r_outcome == ST_OK && w_inrange && !r_undo &&
                        !(r_delta[15] && w_sum < 0) &&
                        !(r_delta == 16'd0 && w_cur != 0) && w_sum <= 17'sd32767)
                        w_sh_we = 1'b1;
                    if (r_last && !r_removed && r_outcome == ST_BLOCKED &&
                        !r_bpoint[6] && {2'b0, r_bpoint[5:0]} < 8'(SLOTS_USED)) begin
                        w_waddr = r_bpoint[IW-1:0];
                        w_wneg_d = (w_wneg != 16'hFFFF) ? w_wneg + 16'd1 : w_wneg;
                        w_wz_d   = (w_wz != 16'hFFFF) ? w_wz + 16'd1 : w_wz;
                        w_wz_we  = r_bpoint[7];
                        w_wneg_we = !r_bpoint[7];
                    end
                end
                MODE_SET: begin
                    w_val_we = !r_removed && w_inrange && r_newval <= 16'd32767;
                    w_req_we = w_val_we;
                end
                MODE_WAITED: begin
                    w_wneg_d = (w_wneg != 16'd0) ? w_wneg - 16'd1 : w_wneg;
                    w_wz_d   = (w_wz != 16'd0) ? w_wz - 16'd1 : w_wz;
                    w_wz_we   = w_inrange && r_wkind;
                    w_wneg_we = w_inrange && !r_wkind;
                end
                default: ;
            endcase
        end
    end

    // A blocked close needs the waiter counts of the stop slot: the read in S_RD
    // goes to the stop slot, and r_idx follows it into S_EXE.
    logic [2:0]  n_st;
    logic [14:0] n_rv;
    logic [R-1:0] n_rr;
    logic [15:0] n_wn, n_wz;
    logic [5:0]  n_bi;
    logic [2:0]  n_outcome;
    logic [7:0]  n_bpoint;
    logic [63:0] n_touched;

    always_comb begin
        n_st = ST_OK; n_rv = '0; n_rr = '0; n_wn = '0; n_wz = '0; n_bi = '0;
        n_outcome = r_outcome; n_bpoint = r_bpoint; n_touched = r_touched;
        case (r_mode)
            MODE_OP: begin
                if (r_outcome == ST_OK) begin
                    if (!w_inrange)        n_outcome = ST_BADINDEX;
                    else if (r_undo)       n_outcome = ST_UNSUP;
                    else if (r_delta[15] && w_sum < 0) begin
                        n_outcome = ST_BLOCKED; n_bpoint = {1'b0, r_nowait, r_idx};
                    end else if (r_delta == 16'd0 && w_cur != 0) begin
                        n_outcome = ST_BLOCKED; n_bpoint = {1'b1, r_nowait, r_idx};
                    end else if (w_sum > 17'sd32767) n_outcome = ST_RANGE;
                    else n_touched[r_idx] = 1'b1;
                end
                if (!r_last) n_st = ST_PENDING;
                else begin
                    n_st = n_outcome;
                    if (r_removed) n_st = ST_REMOVED;
                    else if (n_outcome == ST_BLOCKED) begin
                        n_bi = n_bpoint[5:0];
                        if (n_bpoint[6]) n_st = ST_RETRY;
                    end
                end
            end
            MODE_WAITED: n_st = w_inrange ? ST_OK : ST_BADINDEX;
            MODE_RSVD:   n_st = ST_UNSUP;
            default: begin
                if (r_removed) n_st = ST_REMOVED;
                else if (r_mode == MODE_REMOVE) n_st = ST_OK;
                else if (!w_inrange) n_st = ST_BADINDEX;
                else case (r_mode)
                    MODE_SET:    n_st = (r_newval > 16'd32767) ? ST_RANGE : ST_OK;
                    MODE_GETVAL: n_rv = w_val;
                    MODE_GETREQ: n_rr = w_req;
                    default: begin n_wn = w_wneg; n_wz = w_wz; end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_cnt <= '0; r_sem_count <= 7'd64;
            r_touched <= '0; r_outcome <= ST_OK; r_bpoint <= '0; r_removed <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    // sweep the store to zero, one slot per cycle
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(SLOTS_USED - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cfg_valid) r_sem_count <= i_cfg_data;
                    if (s_axis_tvalid) begin
                        r_mode   <= s_axis_tdata[2:0];
                        r_idx    <= s_axis_tdata[8:3];
                        r_delta  <= s_axis_tdata[24:9];
                        r_nowait <= s_axis_tdata[25];
                        r_undo   <= s_axis_tdata[26];
                        r_reqid  <= s_axis_tdata[26+R:27];
                        r_newval <= s_axis_tdata[42+R:27+R];
                        r_wkind  <= s_axis_tdata[43+R];
                        r_last   <= s_axis_tlast;
                        r_state  <= S_RD;
                    end
                end
                S_RD: begin
                    if (w_swap) r_idx <= r_bpoint[5:0];
                    r_state <= S_EXE;
                end
                S_EXE: begin
                    r_out <= OW'({n_bi, n_wz, n_wn, n_rr, n_rv, n_st});
                    if (r_mode == MODE_OP && r_last && n_outcome == ST_BLOCKED &&
                        r_outcome == ST_OK && !r_removed && !n_bpoint[6]) begin
                        // blocked within this beat: redo the read at stop slot
                        r_touched <= n_touched; r_outcome <= n_outcome;
                        r_bpoint <= n_bpoint;
                        r_idx <= n_bpoint[5:0];
                        r_state <= S_RD;
                    end else if (r_mode == MODE_OP && r_last && n_outcome == ST_OK &&
                                 !r_removed) begin
                        r_touched <= n_touched; r_outcome <= n_outcome;
                        r_bpoint <= n_bpoint;
                        r_cnt <= '0; r_state <= S_CMT;
                    end else if (r_mode == MODE_OP && r_last) begin
                        // close without commit: drop the open set
                        r_touched <= '0; r_outcome <= ST_OK; r_bpoint <= '0;
                        r_state <= S_OUT;
                    end else if (r_mode == MODE_OP) begin
                        r_touched <= n_touched; r_outcome <= n_outcome;
                        r_bpoint <= n_bpoint;
                        r_state <= S_OUT;
                    end else begin
                        if (r_mode == MODE_REMOVE && !r_removed) r_removed <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_CMT: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(SLOTS_USED)) begin
                        r_touched <= '0; r_outcome <= ST_OK; r_bpoint <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> test/tb.sv
// Testbench for atomic_semaphore_set_bank: stream driver, result monitor and
// a cycle-free model of the semaphore bank. Depends on assb_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import assb_pkg::*;

    localparam int R = 22;

    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  idx;
        logic [15:0] delta;
        logic        no_wait;
        logic        undo;
        logic        last;
        logic [R-1:0] req;
        logic [15:0] new_val;
        logic        wait_kind;
    } sem_req_t;

    // highest field first, so status lands in the lowest bits
    typedef struct packed {
        logic [5:0]  blocked_index;
        logic [15:0] zero_waiters;
        logic [15:0] neg_waiters;
        logic [R-1:0] read_req;
        logic [14:0] read_value;
        logic [2:0]  status;
    } sem_rsp_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    atomic_semaphore_set_bank u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        // tdata: mode, sem_index, sem_delta, no_wait, undo_flag, requester_id,
        // new_value, wait_kind (lowest bits first)
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        // tdata: status, read_value, read_requester, negative_waiters,
        // zero_waiters, blocked_index (lowest bits first)
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------- model state
    int unsigned  sem_count_cfg = 64;
    logic [14:0]  sem_val    [64];
    logic [14:0]  shadow_val [64];
    logic [63:0]  touched;
    logic [R-1:0] last_req   [64];
    logic [15:0]  neg_wait   [64];
    logic [15:0]  zero_wait  [64];
    logic [2:0]   open_status;
    logic [7:0]   open_stop;      // index, no_wait at bit 6, zero-wait at bit 7
    logic         bank_removed;

    sem_req_t pending_ops[$];
    sem_rsp_t due_results[$];
    sem_req_t cur_beat;

    int unsigned errors = 0;
    int unsigned beats_in = 0, beats_out = 0, commits = 0, blocks = 0;
    int unsigned cycle_no = 0;

    initial begin
        for (int k = 0; k < 64; k++) begin
            sem_val[k] = '0; shadow_val[k] = '0; last_req[k] = '0;
            neg_wait[k] = '0; zero_wait[k] = '0;
        end
        touched = '0; open_status = ST_OK; open_stop = '0; bank_removed = 1'b0;
    end

    function automatic int unsigned index_limit();
        return (sem_count_cfg < 64) ? sem_count_cfg : 64;
    endfunction

    // Fold one operation element into the open set's working copy.
    function automatic void fold_element(sem_req_t it);
        int cur, d, nv;
        if (open_status != ST_OK) return;
        if (it.idx >= index_limit()) begin
            open_status = ST_BADINDEX;
            return;
        end
        if (it.undo) begin
            open_status = ST_UNSUP;
            return;
        end
        cur = touched[it.idx] ? int'(shadow_val[it.idx]) : int'(sem_val[it.idx]);
        d = int'($signed(it.delta));
        if (d < 0 && cur < -d) begin
            open_status = ST_BLOCKED;
            open_stop = {1'b0, it.no_wait, it.idx};
            return;
        end
        if (d == 0 && cur != 0) begin
            open_status = ST_BLOCKED;
            open_stop = {1'b1, it.no_wait, it.idx};
            return;
        end
        nv = cur + d;
        if (nv > ValueMax) begin
            open_status = ST_RANGE;
            return;
        end
        shadow_val[it.idx] = nv[14:0];
        touched[it.idx] = 1'b1;
    endfunction

    // Work out the one result beat an accepted request produces.
    function automatic sem_rsp_t semaphore_outcome(sem_req_t it);
        sem_rsp_t r = '0;
        logic in_range = it.idx < index_limit();
        r.status = ST_OK;
        if (it.mode == MODE_OP) begin
            fold_element(it);
            if (!it.last) r.status = ST_PENDING;
            else begin
                r.status = open_status;
                if (bank_removed) r.status = ST_REMOVED;
                else if (open_status == ST_OK) begin
                    commits++;
                    for (int k = 0; k < 64; k++)
                        if (touched[k]) begin
                            sem_val[k] = shadow_val[k];
                            last_req[k] = it.req;
                        end
                end else if (open_status == ST_BLOCKED) begin
                    blocks++;
                    r.blocked_index = open_stop[5:0];
                    if (open_stop[6]) r.status = ST_RETRY;
                    else if (open_stop[7]) begin
                        if (zero_wait[open_stop[5:0]] != 16'hFFFF)
                            zero_wait[open_stop[5:0]]++;
                    end else if (neg_wait[open_stop[5:0]] != 16'hFFFF)
                        neg_wait[open_stop[5:0]]++;
                end
                touched = '0; open_status = ST_OK; open_stop = '0;
            end
        end else if (it.mode == MODE_WAITED) begin
            if (!in_range) r.status = ST_BADINDEX;
            else if (it.wait_kind) begin
                if (zero_wait[it.idx] != 0) zero_wait[it.idx]--;
            end else if (neg_wait[it.idx] != 0) neg_wait[it.idx]--;
        end else if (it.mode == MODE_RSVD) r.status = ST_UNSUP;
        else if (bank_removed) r.status = ST_REMOVED;
        else if (it.mode == MODE_REMOVE) bank_removed = 1'b1;
        else if (!in_range) r.status = ST_BADINDEX;
        else if (it.mode == MODE_SET) begin
            if (it.new_val > ValueMax) r.status = ST_RANGE;
            else begin
                sem_val[it.idx] = it.new_val[14:0];
                last_req[it.idx] = it.req;
            end
        end else if (it.mode == MODE_GETVAL) r.read_value = sem_val[it.idx];
        else if (it.mode == MODE_GETREQ) r.read_req = last_req[it.idx];
        else begin
            r.neg_waiters = neg_wait[it.idx];
            r.zero_waiters = zero_wait[it.idx];
        end
        return r;
    endfunction

    function automatic logic [71:0] pack_request(sem_req_t it);
        logic [71:0] d = '0;
        d[2:0] = it.mode;  d[8:3] = it.idx;  d[24:9] = it.delta;
        d[25] = it.no_wait;  d[26] = it.undo;  d[48:27] = it.req;
        d[64:49] = it.new_val;  d[65] = it.wait_kind;
        return d;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        errors++;
        $display("mismatch at result %0d: %s got %0h want %0h", beats_out, what, got, want);
    endtask

    // Idle with a chance of 21 in 100, except in one quiet window.
    function automatic logic idle_now();
        if (cycle_no > 3000 && cycle_no < 9000) return 1'b0;
        return $urandom_range(0, 99) < 21;
    endfunction

    always @(posedge i_clk) cycle_no <= cycle_no + 1;

    // ---------------------------------------------------------------- driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                due_results.push_back(semaphore_outcome(cur_beat));
                beats_in++;
            end
            // Hold the current beat until it is taken; advance otherwise.
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (pending_ops.size() != 0 && !idle_now()) begin
                    cur_beat = pending_ops.pop_front();
                    s_axis_tdata <= pack_request(cur_beat);
                    s_axis_tlast <= cur_beat.last;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        sem_rsp_t got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[77:0];
                beats_out++;
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", got.read_value, want.read_value);
                    if (got.read_req !== want.read_req)
                        report_mismatch("read_requester", got.read_req, want.read_req);
                    if (got.neg_waiters !== want.neg_waiters)
                        report_mismatch("negative_waiters", got.neg_waiters,
                                        want.neg_waiters);
                    if (got.zero_waiters !== want.zero_waiters)
                        report_mismatch("zero_waiters", got.zero_waiters, want.zero_waiters);
                    if (got.blocked_index !== want.blocked_index)
                        report_mismatch("blocked_index", got.blocked_index,
                                        want.blocked_index);
                end
            end
            m_axis_tready <= !idle_now();
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic sem_req_t make_req(logic [2:0] mode, logic [5:0] idx,
                                          logic [15:0] delta, logic last);
        sem_req_t it;
        it.mode = mode;  it.idx = idx;  it.delta = delta;  it.last = last;
        it.no_wait = 1'($urandom_range(0, 1));
        it.undo = 1'b0;
        it.req = R'($urandom_range(0, (1 << R) - 1));
        it.new_val = 16'($urandom_range(0, 65535));
        it.wait_kind = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic queue_op(logic [5:0] idx, int d, logic last, logic nw);
        sem_req_t it = make_req(MODE_OP, idx, d[15:0], last);
        it.no_wait = nw;
        pending_ops.push_back(it);
    endtask

    task automatic queue_mode(logic [2:0] mode, logic [5:0] idx);
        pending_ops.push_back(make_req(mode, idx, 16'($urandom_range(0, 65535)), 1'b1));
    endtask

    task automatic queue_set(logic [5:0] idx, int unsigned v);
        sem_req_t it = make_req(MODE_SET, idx, '0, 1'b1);
        it.new_val = v[15:0];
        pending_ops.push_back(it);
    endtask

    function automatic logic [5:0] pick_index();
        int unsigned lim = (index_limit() == 0) ? 1 : index_limit();
        if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, lim - 1));
    endfunction

    function automatic int pick_delta();
        int unsigned r = $urandom_range(0, 99);
        if (r < 40) return -int'($urandom_range(1, 3));
        if (r < 70) return int'($urandom_range(1, 5));
        if (r < 80) return 0;
        if (r < 90) return int'($signed(16'($urandom_range(0, 65535))));
        return -int'($urandom_range(100, 32768));
    endfunction

    // Mostly well-formed atomic sets with random content, mixed with other modes.
    task automatic queue_random(int unsigned n);
        int unsigned made = 0, len, r;
        sem_req_t it;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                len = $urandom_range(1, 4);
                for (int e = 0; e < len; e++) begin
                    it = make_req(MODE_OP, pick_index(), 16'(pick_delta()), e == len - 1);
                    it.undo = ($urandom_range(0, 99) < 3);
                    if (e == len - 1 && $urandom_range(0, 49) == 0) it.last = 1'b0;
                    pending_ops.push_back(it);
                end
                made += len;
            end else begin
                if (r < 70) begin
                    it = make_req(MODE_SET, pick_index(), '0, 1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 4) != 0) it.new_val = 16'($urandom_range(0, 20));
                end else if (r < 80) it = make_req(MODE_GETVAL, pick_index(), '0, 1'b1);
                else if (r < 85) it = make_req(MODE_GETREQ, pick_index(), '0, 1'b0);
                else if (r < 90) it = make_req(MODE_GETWT, pick_index(), '0, 1'b1);
                else if (r < 98) it = make_req(MODE_WAITED, pick_index(), '0, 1'b0);
                else it = make_req(MODE_RSVD, pick_index(), '0, 1'b1);
                it.delta = 16'($urandom_range(0, 65535));
                pending_ops.push_back(it);
                made++;
            end
        end
    endtask

    // Drain everything, then let a commit walk finish before touching config.
    task automatic drain();
        while (pending_ops.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_count(logic [6:0] v);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sem_count_cfg = v;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_count(7'd127);
        // Directed: value extremes, range errors, blocking kinds, open set.
        queue_set(6'd0, 32767);
        queue_set(6'd1, 32768);
        queue_set(6'd2, 65535);
        queue_mode(MODE_GETVAL, 6'd0);
        queue_op(6'd0, 1, 1'b1, 1'b0);          // sum above the top value
        queue_op(6'd3, -32768, 1'b1, 1'b0);     // take blocks, counts a waiter
        queue_op(6'd0, 0, 1'b1, 1'b1);          // zero-wait blocks, retry
        queue_op(6'd0, 0, 1'b1, 1'b0);          // zero-wait blocks, counts
        queue_mode(MODE_GETWT, 6'd0);
        queue_mode(MODE_GETWT, 6'd3);
        queue_op(6'd4, 32767, 1'b0, 1'b0);      // open set, interleaved reads
        queue_mode(MODE_GETVAL, 6'd4);
        queue_op(6'd4, -32767, 1'b0, 1'b0);
        queue_op(6'd63, 5, 1'b1, 1'b0);
        queue_mode(MODE_GETREQ, 6'd63);
        begin
            sem_req_t u = make_req(MODE_OP, 6'd5, 16'd1, 1'b1);
            u.undo = 1'b1;
            pending_ops.push_back(u);
        end
        queue_mode(MODE_WAITED, 6'd0);
        queue_mode(MODE_WAITED, 6'd9);          // wait ended at zero stays zero
        queue_mode(MODE_RSVD, 6'd1);
        queue_set(6'd0, 0);
        queue_mode(MODE_GETREQ, 6'd0);
        queue_random(500);
        drain();

        write_count(7'd0);                      // every index out of range
        queue_op(6'd0, 1, 1'b1, 1'b0);
        queue_random(60);
        drain();
        write_count(7'd1);
        queue_random(150);
        drain();
        write_count(7'd23);
        queue_random(280);
        drain();
        write_count(7'd64);
        queue_random(280);
        // Remove the bank, then show every mode but GETREQ afterwards.
        queue_mode(MODE_REMOVE, 6'd63);
        queue_mode(MODE_REMOVE, 6'd0);
        queue_set(6'd1, 7);
        queue_mode(MODE_GETVAL, 6'd1);
        queue_op(6'd1, 1, 1'b1, 1'b0);
        queue_mode(MODE_WAITED, 6'd3);
        queue_mode(MODE_GETWT, 6'd3);
        queue_mode(MODE_RSVD, 6'd2);
        drain();

        $display("covered %0d request beats, %0d result beats", beats_in, beats_out);
        $display("sets committed: %0d, sets blocked: %0d", commits, blocks);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
